/* src/lph_pkg.sv */
// Shared types, widths and codes for the linear probing hash table.
package lph_pkg;

    // Table geometry. The slot count is a power of two, so the home slot is the low key bits.
    localparam int TABLE_SIZE = 16;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    // Field widths of the channels and the register.
    localparam int KEY_W      = 31;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int LIMIT_W    = 5;
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Register file of the configuration port.
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;
    localparam logic REG_OCC_LIMIT     = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd4;

    // Access request from the sequencer to the slot memory.
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } t_slot_req;

endpackage

/* src/lph_ifs.sv */
// Handshake interfaces for the request and result channels.
interface lph_req_if;
    import lph_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [KEY_W-1:0] key;
    modport source (output valid, command, key, input ready);
    modport sink (input valid, command, key, output ready);
endinterface

interface lph_rsp_if;
    import lph_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    modport source (output valid, status, slot_index, input ready);
    modport sink (input valid, status, slot_index, output ready);
endinterface

/* src/lph_slots.sv */
// Key slot memory with per-entry valid bits; an unwritten slot reads as empty.
module lph_slots (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lph_pkg::t_slot_req         i_req,
    output logic [lph_pkg::KEY_W-1:0]  o_rd_data
);
    import lph_pkg::*;

    logic [KEY_W-1:0]      r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_vld;
    logic [KEY_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    // Key storage, written at one address and read at one address per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    // Valid bits are cleared at reset so the whole table reads as empty at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* src/lph_ctrl.sv */
// Probe sequencer: one slot compare per cycle, occupancy count and result register.
module lph_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lph_pkg::LIMIT_W-1:0]  i_limit,
    lph_req_if.sink                      i_req,
    lph_rsp_if.source                    o_rsp,
    output lph_pkg::t_slot_req           o_slot_req,
    input  logic [lph_pkg::KEY_W-1:0]    i_rd_data
);
    import lph_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_PROBE = SLOT_W'(TABLE_SIZE - 1);

    logic [1:0]            r_state, n_state;
    logic                  r_cmd, n_cmd;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [SLOT_W-1:0]     r_probes, n_probes;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot, n_out_slot;
    logic                  at_limit;
    logic                  slot_empty;
    logic                  slot_match;
    logic                  last_probe;

    assign at_limit   = (CMP_W'(r_count) >= CMP_W'(i_limit)) ||
                        (CMP_W'(r_count) >= CMP_W'(TABLE_SIZE));
    assign slot_empty = (i_rd_data == '0);
    assign slot_match = (i_rd_data == r_key);
    assign last_probe = (r_probes == LAST_PROBE);

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_slot;

    // Sequencer: latch the request, walk the probe sequence, then hand off the result.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_slot       = r_slot;
        n_probes     = r_probes;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;

        o_slot_req         = '0;
        o_slot_req.rd_addr = r_slot + SLOT_W'(1);
        o_slot_req.wr_addr = r_slot;
        o_slot_req.wr_data = r_key;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_cmd              = i_req.command;
                    n_key              = i_req.key;
                    n_slot             = i_req.key[SLOT_W-1:0];
                    n_probes           = '0;
                    n_res_slot         = '0;
                    o_slot_req.rd_addr = i_req.key[SLOT_W-1:0];
                    if (i_req.key == '0) begin
                        n_res_status = ST_BAD_KEY;
                        n_state      = ST_FINISH;
                    end else if (i_req.command == CMD_INSERT && at_limit) begin
                        n_res_status = ST_REFUSED;
                        n_state      = ST_FINISH;
                    end else begin
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (slot_empty) begin
                        o_slot_req.wr_en = 1'b1;
                        n_count          = r_count + CNT_W'(1);
                        n_res_status     = ST_INSERTED;
                        n_res_slot       = r_slot;
                        n_state          = ST_FINISH;
                    end else if (last_probe) begin
                        n_res_status = ST_REFUSED;
                        n_state      = ST_FINISH;
                    end else begin
                        n_slot   = r_slot + SLOT_W'(1);
                        n_probes = r_probes + SLOT_W'(1);
                    end
                end else begin
                    if (slot_match) begin
                        n_res_status = ST_FOUND;
                        n_res_slot   = r_slot;
                        n_state      = ST_FINISH;
                    end else if (slot_empty || last_probe) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = ST_FINISH;
                    end else begin
                        n_slot   = r_slot + SLOT_W'(1);
                        n_probes = r_probes + SLOT_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = SLOT_OUT_W'(r_res_slot);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current request and the result payload.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_probes     <= n_probes;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // The table never holds more keys than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(TABLE_SIZE))
        else $error("occupancy count exceeds table size");

    // Only an insert probe writes the memory.
    a_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot_req.wr_en |-> (r_state == ST_PROBE && r_cmd == CMD_INSERT && r_key != '0))
        else $error("slot write outside an insert probe");

    // Every stored key raises the occupancy count by one.
    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot_req.wr_en |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("occupancy count did not follow a slot write");

    // A probe walk always starts on its first probe.
    a_probe_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_PROBE) |=> (r_probes == '0))
        else $error("probe counter not cleared at start of walk");

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> r_out_valid)
        else $error("pending result lost");

endmodule

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: configuration port, sequencer and slot memory.
//
//  Channel  Direction  Transfer when                   Payload
//  i_req    in         i_req.valid && i_req.ready      command, key
//  o_rsp    out        o_rsp.valid && o_rsp.ready      status, slot_index
//  APB      in         psel && penable && pwrite       occupancy_limit at byte address 0
//
// A request is taken only while the sequencer is idle and keeps it busy through an accept
// step, one probe step per probed slot (at most 16 slots, one per table slot), and a step
// that loads the result register. A zero key or a refused insert skips the probe steps.
// The result register holds a finished result while the next request is taken;
// the next result then waits in its load step until the held one has made its transfer.
// Reset is synchronous; it empties the table at once through the slot valid bits.
module linear_probe_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lph_req_if.sink                       i_req,
    lph_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lph_pkg::PADDR_W-1:0]   paddr,
    input  logic [lph_pkg::PDATA_W-1:0]   pwdata,
    output logic [lph_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import lph_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               reg_sel;
    t_slot_req          slot_req;
    logic [KEY_W-1:0]   rd_data;

    // Register decode: one 32-bit word per register.
    assign reg_sel = (paddr[PADDR_W-1] == REG_OCC_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(r_limit) : '0;

    // Occupancy limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    lph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_limit),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_slot_req (slot_req),
        .i_rd_data  (rd_data)
    );

    lph_slots u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (slot_req),
        .o_rd_data (rd_data)
    );

endmodule
